[rtl/hpil_pkg.sv]
// Shared types, frame codes and the device-ID table of the loop device interface.
package hpil_pkg;

  localparam int FRAME_W = 11;
  localparam int BYTE_W  = 8;
  localparam int PTR_W   = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Address assigned by the auto-address unconfigure command.
  localparam logic [4:0] DEFAULT_ADDRESS = 5'd31;

  // Frame classes, bits 10..8.
  localparam logic [2:0] CLASS_CMD   = 3'b100;
  localparam logic [2:0] CLASS_READY = 3'b101;

  localparam logic [FRAME_W-1:0] EOT_FRAME = 11'h540;

  // Command groups, payload bits 7..5.
  localparam logic [2:0] GRP_UNIVERSAL = 3'd0;
  localparam logic [2:0] GRP_LISTEN    = 3'd1;
  localparam logic [2:0] GRP_TALK      = 3'd2;
  localparam logic [2:0] GRP_SPECIAL   = 3'd4;

  localparam logic [7:0] CMD_SDC = 8'd4;
  localparam logic [7:0] CMD_DCL = 8'd20;
  localparam logic [4:0] LOW_UNADDRESS = 5'd31;
  localparam logic [4:0] LOW_IFC = 5'd16;
  localparam logic [4:0] LOW_AAU = 5'd26;

  localparam logic [7:0] RDY_NRD = 8'd66;
  localparam logic [7:0] RDY_SST = 8'd97;
  localparam logic [7:0] RDY_SDI = 8'd98;
  localparam logic [7:0] RDY_SAI = 8'd99;
  localparam logic [7:0] RDY_AAD_LIMIT = 8'h9E;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [PTR_W-1:0] ID_LEN = 4'd10;

  // Configuration register indexes.
  localparam logic CFG_ACCESSORY_ID = 1'b0;
  localparam logic CFG_STATUS_BYTE  = 1'b1;

  // Bit 1 is the listen/active flag, bit 0 the talker flag.
  typedef enum logic [1:0] {
    ROLE_IDLE     = 2'b00,
    ROLE_TALKER   = 2'b01,
    ROLE_LISTENER = 2'b10,
    ROLE_ACTIVE   = 2'b11
  } role_t;

  function automatic logic [7:0] dev_id_char(input logic [PTR_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4D;
      4'd1:    c = 8'h43;
      4'd2:    c = 8'h30;
      4'd3:    c = 8'h30;
      4'd4:    c = 8'h37;
      4'd5:    c = 8'h30;
      4'd6:    c = 8'h31;
      4'd7:    c = 8'h41;
      4'd8:    c = 8'h0D;
      4'd9:    c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/hpil_device_interface.sv]
// Loop device interface: listener/talker decode of loop frames for a display accessory.

// One loop frame is accepted per clock cycle while the slave side is not stalled. A frame
// taken into the input register is decoded there against the role, address and
// ID-pointer registers and written to the result register, which drives the master side.
// The result register holds an item until the master side takes it; while it waits, one
// more frame can sit in the input register before the slave side stalls. The device
// state advances when a frame moves from the input register to the result register, so
// frames are handled strictly in order. The configuration port is always ready and takes
// one write per cycle.
module hpil_device_interface #(
  parameter logic [4:0] DEFAULT_ADDRESS = hpil_pkg::DEFAULT_ADDRESS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: [10:0] loop_frame, [15:11] zero
  input  logic [hpil_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: [10:0] out_frame, [11] display_valid, [19:12] display_byte,
  //          [20] display_clear, [23:21] zero
  output logic [hpil_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] accessory_id;
  logic [7:0] status_byte;

  hpil_pkg::role_t role, role_next;
  logic [7:0] loop_address, loop_address_next;
  logic [hpil_pkg::PTR_W-1:0] id_pointer, id_pointer_next;

  logic in_valid;
  logic [hpil_pkg::FRAME_W-1:0] in_frame;

  logic out_valid;
  logic [hpil_pkg::FRAME_W-1:0] out_frame, out_frame_next;
  logic out_display_valid, display_valid_next;
  logic [7:0] out_display_byte, display_byte_next;
  logic out_display_clear, display_clear_next;

  logic advance;
  logic [7:0] payload;
  logic [2:0] frame_class;
  logic [2:0] cmd_group;
  logic [4:0] cmd_low;
  logic [4:0] my_address;
  logic is_data;

  logic [hpil_pkg::PTR_W-1:0] id_index;
  logic [7:0] id_char;
  logic [hpil_pkg::PTR_W-1:0] id_step;
  logic id_done;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  assign payload     = in_frame[7:0];
  assign frame_class = in_frame[10:8];
  assign cmd_group   = payload[7:5];
  assign cmd_low     = payload[4:0];
  assign my_address  = loop_address[4:0];
  assign is_data     = !in_frame[10];

  // Next device-ID character and where the pointer goes after sending it.
  assign id_index = id_pointer - 4'd1;
  assign id_char  = hpil_pkg::dev_id_char(id_index);
  always_comb begin
    if (id_pointer == '0) begin
      id_step = '0;
    end else if (id_index < hpil_pkg::ID_LEN) begin
      id_step = (id_char == hpil_pkg::CHAR_CR) ? '0 : 4'(id_pointer + 4'd1);
    end else begin
      id_step = '0;
    end
  end
  assign id_done = (id_step == '0);

  // Next state of role, address and ID pointer.
  always_comb begin
    role_next         = role;
    loop_address_next = loop_address;
    id_pointer_next   = id_pointer;
    if (is_data) begin
      if (role == hpil_pkg::ROLE_ACTIVE) begin
        id_pointer_next = id_step;
        if (id_done) begin
          role_next = hpil_pkg::ROLE_TALKER;
        end
      end
    end else if (frame_class == hpil_pkg::CLASS_CMD) begin
      case (cmd_group)
        hpil_pkg::GRP_LISTEN: begin
          if (cmd_low == hpil_pkg::LOW_UNADDRESS) begin
            if (!role[0]) role_next = hpil_pkg::ROLE_IDLE;
          end else if (cmd_low == my_address) begin
            role_next = hpil_pkg::ROLE_LISTENER;
          end
        end
        hpil_pkg::GRP_TALK: begin
          if (cmd_low == my_address) begin
            role_next = hpil_pkg::ROLE_TALKER;
          end else if (role[0]) begin
            role_next = hpil_pkg::ROLE_IDLE;
          end
        end
        hpil_pkg::GRP_SPECIAL: begin
          if (cmd_low == hpil_pkg::LOW_IFC) begin
            role_next = hpil_pkg::ROLE_IDLE;
          end else if (cmd_low == hpil_pkg::LOW_AAU) begin
            loop_address_next = {3'b000, DEFAULT_ADDRESS};
          end
        end
        default: begin
        end
      endcase
    end else if (frame_class == hpil_pkg::CLASS_READY) begin
      if (!payload[7]) begin
        if (role[0]) begin
          case (payload)
            hpil_pkg::RDY_NRD: id_pointer_next = '0;
            hpil_pkg::RDY_SST: role_next = hpil_pkg::ROLE_ACTIVE;
            hpil_pkg::RDY_SDI: begin
              id_pointer_next = 4'd2;
              role_next       = hpil_pkg::ROLE_ACTIVE;
            end
            hpil_pkg::RDY_SAI: role_next = hpil_pkg::ROLE_ACTIVE;
            default: begin
            end
          endcase
        end
      end else if (payload < hpil_pkg::RDY_AAD_LIMIT && !loop_address[7]) begin
        loop_address_next = payload;
      end
    end
  end

  // Result item for the frame in the input register.
  always_comb begin
    out_frame_next     = in_frame;
    display_valid_next = 1'b0;
    display_byte_next  = '0;
    display_clear_next = 1'b0;
    if (is_data) begin
      if (role == hpil_pkg::ROLE_ACTIVE) begin
        if (id_done) begin
          out_frame_next = hpil_pkg::EOT_FRAME;
        end else begin
          out_frame_next = {3'b000, id_char};
        end
      end else if (role == hpil_pkg::ROLE_LISTENER) begin
        display_valid_next = 1'b1;
        display_byte_next  = payload;
      end
    end else if (frame_class == hpil_pkg::CLASS_CMD) begin
      if (cmd_group == hpil_pkg::GRP_UNIVERSAL) begin
        if (payload == hpil_pkg::CMD_SDC) begin
          display_clear_next = role[1];
        end else if (payload == hpil_pkg::CMD_DCL) begin
          display_clear_next = 1'b1;
        end
      end
    end else if (frame_class == hpil_pkg::CLASS_READY) begin
      if (!payload[7]) begin
        if (role[0]) begin
          case (payload)
            hpil_pkg::RDY_SST: out_frame_next = {3'b000, status_byte};
            hpil_pkg::RDY_SDI: out_frame_next = {3'b000, hpil_pkg::dev_id_char('0)};
            hpil_pkg::RDY_SAI: out_frame_next = {3'b000, accessory_id};
            default: begin
            end
          endcase
        end
      end else if (payload < hpil_pkg::RDY_AAD_LIMIT && !loop_address[7]) begin
        out_frame_next = 11'(in_frame + 11'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accessory_id <= 8'd50;
      status_byte  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hpil_pkg::CFG_ACCESSORY_ID: accessory_id <= cfg_data;
        hpil_pkg::CFG_STATUS_BYTE:  status_byte  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      role         <= hpil_pkg::ROLE_IDLE;
      loop_address <= '0;
      id_pointer   <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid    <= 1'b1;
        role         <= role_next;
        loop_address <= loop_address_next;
        id_pointer   <= id_pointer_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_frame <= s_tdata[hpil_pkg::FRAME_W-1:0];
    end
    if (advance) begin
      out_frame         <= out_frame_next;
      out_display_valid <= display_valid_next;
      out_display_byte  <= display_byte_next;
      out_display_clear <= display_clear_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_display_clear, out_display_byte, out_display_valid, out_frame};

`ifndef ASSERT_OFF
  // A data frame taken while addressed listener reaches the display unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (advance && is_data && role == hpil_pkg::ROLE_LISTENER)
      |=> (out_display_valid && out_frame == $past(in_frame)))
    else $error("listener data frame not handed to the display");

  // The ID pointer stops at the CR character and never runs past it.
  assert property (@(posedge clk) disable iff (rst)
    id_pointer <= 4'd9)
    else $error("device-ID pointer ran past the end of the string");

  // Only a ready frame makes the device an active talker.
  assert property (@(posedge clk) disable iff (rst)
    (role == hpil_pkg::ROLE_ACTIVE && $past(role) != hpil_pkg::ROLE_ACTIVE)
      |-> $past(advance && frame_class == hpil_pkg::CLASS_READY))
    else $error("active talker entered without a ready frame");
`endif

endmodule

[tb/tb_hpil_device_interface.sv]
// Self-checking testbench for the loop device interface: directed table, then random frames.
module tb_hpil_device_interface;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 400;
  localparam int NUM_PHASES = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Device-ID characters, CR and LF last, first character in the top byte.
  localparam logic [79:0] ID_STRING = 80'h4D43_3030_3730_3141_0D0A;

  // Same bit order as m_tdata[20:0].
  typedef struct packed {
    logic                         clear;
    logic [hpil_pkg::BYTE_W-1:0]  dbyte;
    logic                         dvalid;
    logic [hpil_pkg::FRAME_W-1:0] frame;
  } frame_result_t;

  typedef struct packed {
    logic [hpil_pkg::FRAME_W-1:0] frame;
    logic                         known;
    frame_result_t                want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [hpil_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [hpil_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = hpil_pkg::CFG_ACCESSORY_ID;
  logic [7:0] cfg_data = '0;

  // Predicted device state and register copies.
  hpil_pkg::role_t            role = hpil_pkg::ROLE_IDLE;
  logic [7:0]                 loop_addr = '0;
  logic [hpil_pkg::PTR_W-1:0] id_ptr = '0;
  logic [7:0]                 accessory_reg = 8'd50;
  logic [7:0]                 status_reg = 8'd0;

  frame_result_t expected_frames[$];
  int errors = 0;
  bit steady = 1'b0;

  hpil_device_interface DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic frame_result_t outcome(input logic [hpil_pkg::FRAME_W-1:0] f,
                                            input logic dv,
                                            input logic [7:0] db, input logic dc);
    frame_result_t r;
    r.frame = f;
    r.dvalid = dv;
    r.dbyte = db;
    r.clear = dc;
    return r;
  endfunction

  function automatic stim_row_t row_plain(input logic [hpil_pkg::FRAME_W-1:0] f);
    return {f, 1'b0, frame_result_t'('0)};
  endfunction

  function automatic stim_row_t row_known(input logic [hpil_pkg::FRAME_W-1:0] f,
                                          input frame_result_t w);
    return {f, 1'b1, w};
  endfunction

  // Works out the frame passed on and the display strobes, and advances the device state.
  function automatic frame_result_t decode_frame(input logic [hpil_pkg::FRAME_W-1:0] f);
    frame_result_t r;
    logic [7:0] pl;
    logic [4:0] low;
    logic [hpil_pkg::PTR_W-1:0] idx;
    logic [7:0] ch;
    r = '0;
    r.frame = f;
    pl = f[7:0];
    low = pl[4:0];
    if (!f[10]) begin
      if (role[1]) begin
        if (role[0]) begin
          if (id_ptr != 0) begin
            idx = id_ptr - 1'b1;
            if (idx < hpil_pkg::ID_LEN) begin
              ch = ID_STRING[79 - 8*idx -: 8];
              r.frame = {3'b000, ch};
              if (ch == hpil_pkg::CHAR_CR) id_ptr = '0;
              else id_ptr = id_ptr + 1'b1;
            end else begin
              id_ptr = '0;
            end
          end
          // No character left to send: close the transfer with EOT.
          if (id_ptr == 0) begin
            r.frame = hpil_pkg::EOT_FRAME;
            role = hpil_pkg::ROLE_TALKER;
          end
        end else begin
          r.dvalid = 1'b1;
          r.dbyte = pl;
        end
      end
    end else if (f[10:8] == hpil_pkg::CLASS_CMD) begin
      case (pl[7:5])
        hpil_pkg::GRP_UNIVERSAL: begin
          if (pl == hpil_pkg::CMD_SDC) r.clear = role[1];
          else if (pl == hpil_pkg::CMD_DCL) r.clear = 1'b1;
        end
        hpil_pkg::GRP_LISTEN: begin
          if (low == hpil_pkg::LOW_UNADDRESS) begin
            if (!role[0]) role = hpil_pkg::ROLE_IDLE;
          end else if (low == loop_addr[4:0]) begin
            role = hpil_pkg::ROLE_LISTENER;
          end
        end
        hpil_pkg::GRP_TALK: begin
          if (low == loop_addr[4:0]) role = hpil_pkg::ROLE_TALKER;
          else if (role[0]) role = hpil_pkg::ROLE_IDLE;
        end
        hpil_pkg::GRP_SPECIAL: begin
          if (low == hpil_pkg::LOW_IFC) role = hpil_pkg::ROLE_IDLE;
          else if (low == hpil_pkg::LOW_AAU) loop_addr = {3'b000, hpil_pkg::DEFAULT_ADDRESS};
        end
        default: ;
      endcase
    end else if (f[10:8] == hpil_pkg::CLASS_READY) begin
      if (!pl[7]) begin
        if (role[0]) begin
          case (pl)
            hpil_pkg::RDY_NRD: id_ptr = '0;
            hpil_pkg::RDY_SST: begin
              r.frame = {3'b000, status_reg};
              role = hpil_pkg::ROLE_ACTIVE;
            end
            hpil_pkg::RDY_SDI: begin
              r.frame = {3'b000, ID_STRING[79 -: 8]};
              id_ptr = 4'd2;
              role = hpil_pkg::ROLE_ACTIVE;
            end
            hpil_pkg::RDY_SAI: begin
              r.frame = {3'b000, accessory_reg};
              role = hpil_pkg::ROLE_ACTIVE;
            end
            default: ;
          endcase
        end
      end else if (pl < hpil_pkg::RDY_AAD_LIMIT) begin
        // Auto address: take the payload once and pass the frame on incremented.
        if (!loop_addr[7]) begin
          loop_addr = pl;
          r.frame = f + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Random frame, weighted toward addressing and talker sequences for the current state.
  function automatic logic [hpil_pkg::FRAME_W-1:0] pick_frame();
    int k;
    logic [4:0] low5;
    logic [hpil_pkg::FRAME_W-1:0] f;
    k = $urandom_range(0, 99);
    low5 = ($urandom_range(0, 1) == 1) ? loop_addr[4:0] : 5'($urandom_range(0, 31));
    if (k < 35) begin
      f = {1'b0, 10'($urandom_range(0, 1023))};
    end else if (k < 43) begin
      f = {hpil_pkg::CLASS_CMD, hpil_pkg::GRP_LISTEN, low5};
    end else if (k < 51) begin
      f = {hpil_pkg::CLASS_CMD, hpil_pkg::GRP_TALK, low5};
    end else if (k < 54) begin
      f = {hpil_pkg::CLASS_CMD, hpil_pkg::GRP_LISTEN, hpil_pkg::LOW_UNADDRESS};
    end else if (k < 59) begin
      case ($urandom_range(0, 2))
        0: f = {hpil_pkg::CLASS_CMD, hpil_pkg::CMD_SDC};
        1: f = {hpil_pkg::CLASS_CMD, hpil_pkg::CMD_DCL};
        default: f = {hpil_pkg::CLASS_CMD, hpil_pkg::GRP_UNIVERSAL, 5'($urandom_range(0, 31))};
      endcase
    end else if (k < 63) begin
      case ($urandom_range(0, 2))
        0: f = {hpil_pkg::CLASS_CMD, hpil_pkg::GRP_SPECIAL, hpil_pkg::LOW_IFC};
        1: f = {hpil_pkg::CLASS_CMD, hpil_pkg::GRP_SPECIAL, hpil_pkg::LOW_AAU};
        default: f = {hpil_pkg::CLASS_CMD, 8'($urandom_range(0, 255))};
      endcase
    end else if (k < 78) begin
      case ($urandom_range(0, 7))
        0: f = {hpil_pkg::CLASS_READY, hpil_pkg::RDY_NRD};
        1, 2: f = {hpil_pkg::CLASS_READY, hpil_pkg::RDY_SST};
        3, 4, 5: f = {hpil_pkg::CLASS_READY, hpil_pkg::RDY_SDI};
        default: f = {hpil_pkg::CLASS_READY, hpil_pkg::RDY_SAI};
      endcase
    end else if (k < 86) begin
      f = {hpil_pkg::CLASS_READY, 1'b1, 7'($urandom_range(0, 127))};
    end else if (k < 91) begin
      f = {hpil_pkg::CLASS_READY, 8'($urandom_range(0, 255))};
    end else if (k < 96) begin
      f = {2'b11, 9'($urandom_range(0, 511))};
    end else begin
      f = 11'($urandom_range(0, 2047));
    end
    return f;
  endfunction

  task automatic send_frame(input logic [hpil_pkg::FRAME_W-1:0] f, input logic known,
                            input frame_result_t want);
    frame_result_t r;
    if (!steady) begin
      while ($urandom_range(0, 99) < 23) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(hpil_pkg::IN_TDATA_W-hpil_pkg::FRAME_W){1'b0}}, f};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = decode_frame(f);
    expected_frames.push_back(known ? want : r);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == hpil_pkg::CFG_ACCESSORY_ID) accessory_reg = v;
    else status_reg = v;
  endtask

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  // Receiver side: random stalls except during the steady phase.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 23);
  end

  frame_result_t got_res, want_res;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = m_tdata[20:0];
      if (expected_frames.size() == 0) begin
        report("unexpected item", 16'(got_res.frame), 16'h0);
      end else begin
        want_res = expected_frames.pop_front();
        if (got_res.frame !== want_res.frame)
          report("out_frame", 16'(got_res.frame), 16'(want_res.frame));
        if (got_res.dvalid !== want_res.dvalid)
          report("display_valid", 16'(got_res.dvalid), 16'(want_res.dvalid));
        if (got_res.dbyte !== want_res.dbyte)
          report("display_byte", 16'(got_res.dbyte), 16'(want_res.dbyte));
        if (got_res.clear !== want_res.clear)
          report("display_clear", 16'(got_res.clear), 16'(want_res.clear));
      end
    end
  end

  int stall_cycles = 0;

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  stim_row_t dir_rows[$];
  logic [7:0] acc_val, stat_val;

  initial begin
    dir_rows = '{
      row_known(11'h3FF, outcome(11'h3FF, 1'b0, 8'h00, 1'b0)),
      row_known(11'h7FF, outcome(11'h7FF, 1'b0, 8'h00, 1'b0)),
      row_known({hpil_pkg::CLASS_CMD, hpil_pkg::CMD_DCL},
                outcome({hpil_pkg::CLASS_CMD, hpil_pkg::CMD_DCL}, 1'b0, 8'h00, 1'b1)),
      row_known({hpil_pkg::CLASS_CMD, hpil_pkg::CMD_SDC},
                outcome({hpil_pkg::CLASS_CMD, hpil_pkg::CMD_SDC}, 1'b0, 8'h00, 1'b0)),
      row_plain({hpil_pkg::CLASS_READY, hpil_pkg::RDY_SST}),
      row_plain({hpil_pkg::CLASS_CMD, hpil_pkg::GRP_LISTEN, 5'd0}),
      row_known({hpil_pkg::CLASS_CMD, hpil_pkg::CMD_SDC},
                outcome({hpil_pkg::CLASS_CMD, hpil_pkg::CMD_SDC}, 1'b0, 8'h00, 1'b1)),
      row_known(11'h0A5, outcome(11'h0A5, 1'b1, 8'hA5, 1'b0)),
      row_plain({hpil_pkg::CLASS_CMD, hpil_pkg::GRP_LISTEN, hpil_pkg::LOW_UNADDRESS}),
      row_plain({hpil_pkg::CLASS_CMD, hpil_pkg::GRP_TALK, 5'd0}),
      row_plain({hpil_pkg::CLASS_READY, hpil_pkg::RDY_SST}),
      row_known(11'h2FF, outcome(hpil_pkg::EOT_FRAME, 1'b0, 8'h00, 1'b0)),
      row_plain({hpil_pkg::CLASS_READY, hpil_pkg::RDY_SDI}),
      row_plain(11'h155), row_plain(11'h2AA), row_plain(11'h000), row_plain(11'h3FF),
      row_plain(11'h001), row_plain(11'h200), row_plain(11'h0F0),
      row_plain(11'h10F),
      row_known({hpil_pkg::CLASS_READY, hpil_pkg::RDY_SAI},
                outcome(11'h032, 1'b0, 8'h00, 1'b0)),
      row_plain({hpil_pkg::CLASS_READY, hpil_pkg::RDY_NRD}),
      row_plain({hpil_pkg::CLASS_CMD, hpil_pkg::GRP_SPECIAL, hpil_pkg::LOW_AAU}),
      row_known({hpil_pkg::CLASS_READY, 8'h80}, outcome(11'h581, 1'b0, 8'h00, 1'b0)),
      row_plain({hpil_pkg::CLASS_READY, 8'hFF})
    };
    role = hpil_pkg::ROLE_IDLE;
    loop_addr = '0;
    id_ptr = '0;
    accessory_reg = 8'd50;
    status_reg = 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_frame(dir_rows[i].frame, dir_rows[i].known, dir_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Registers change only with the pipeline empty.
      wait_results();
      case (p)
        0: begin acc_val = 8'h00; stat_val = 8'hFF; end
        1: begin acc_val = 8'hFF; stat_val = 8'h00; end
        3: begin acc_val = 8'hFF; stat_val = 8'hFF; end
        4: begin acc_val = 8'h00; stat_val = 8'h00; end
        default: begin
          acc_val = 8'($urandom_range(0, 255));
          stat_val = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(hpil_pkg::CFG_ACCESSORY_ID, acc_val);
      write_reg(hpil_pkg::CFG_STATUS_BYTE, stat_val);
      cfg_valid <= 1'b0;
      steady = (p == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_frame(pick_frame(), 1'b0, frame_result_t'('0));
    end
    steady = 1'b0;

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
